FILE: rtl/sorted_priority_queue_top_assert.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define SPQ_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("sorted priority queue check failed");

// condition implies consequence in the cycle after
`define SPQ_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

FILE: rtl/spq_pkg.sv
// package: types and constants of the sorted priority queue
package spq_pkg;

    localparam int SPQ_QUEUE_DEPTH = 16;
    localparam int SPQ_TAG_BITS    = 16;

    // field widths of the beats
    localparam int WORD_TAG_W  = 16;
    localparam int PRIORITY_W  = 32;
    localparam int ENTRY_CNT_W = 5;

    // command codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic                         mode;
        logic [WORD_TAG_W-1:0]        word_tag;
        logic signed [PRIORITY_W-1:0] priority_req;
    } spq_cmd_t;

    typedef struct packed {
        spq_status_t                  status;
        logic                         head_valid;
        logic [WORD_TAG_W-1:0]        head_tag;
        logic signed [PRIORITY_W-1:0] head_priority;
        logic [ENTRY_CNT_W-1:0]       entry_count;
    } spq_rsp_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } spq_ctl_t;

endpackage

FILE: rtl/spq_cell.sv
// one slot of the sorted chain: holds an entry, shifts right on insert, left on pop
module spq_cell #(
    parameter int TAG_BITS = spq_pkg::SPQ_TAG_BITS
) (
    input  logic                                  clk,
    input  spq_pkg::spq_ctl_t                     ctl,
    input  logic                                  occupied,
    input  logic [TAG_BITS-1:0]                   new_tag,
    input  logic signed [spq_pkg::PRIORITY_W-1:0] new_prio,
    input  logic                                  left_gt,
    input  logic [TAG_BITS-1:0]                   left_tag,
    input  logic signed [spq_pkg::PRIORITY_W-1:0] left_prio,
    input  logic [TAG_BITS-1:0]                   right_tag,
    input  logic signed [spq_pkg::PRIORITY_W-1:0] right_prio,
    output logic                                  gt,
    output logic [TAG_BITS-1:0]                   tag,
    output logic signed [spq_pkg::PRIORITY_W-1:0] prio,
    output logic [TAG_BITS-1:0]                   tag_next,
    output logic signed [spq_pkg::PRIORITY_W-1:0] prio_next
);
    import spq_pkg::*;

    logic [TAG_BITS-1:0]          tag_reg;
    logic signed [PRIORITY_W-1:0] prio_reg;

    // new entry belongs ahead of this slot: slot empty or strictly lower priority
    assign gt = !occupied || (prio_reg < new_prio);

    // slot select: keep, take new, take left neighbor, take right neighbor
    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (ctl.ins)
        begin
            if (left_gt)
            begin
                tag_next  = left_tag;
                prio_next = left_prio;
            end
            else if (gt)
            begin
                tag_next  = new_tag;
                prio_next = new_prio;
            end
        end
        else if (ctl.pop)
        begin
            tag_next  = right_tag;
            prio_next = right_prio;
        end
    end

    // slot storage, payload only
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign tag  = tag_reg;
    assign prio = prio_reg;

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// top level of the sorted priority queue: cell chain, count and result register
//
//  channel   handshake        payload     direction
//  command   start / busy     cmd         in
//  result    done (strobe)    rsp         out
//
// busy stays low, so each command beat is taken when start is high and a beat may come every cycle
// the result beat shows on rsp with done high in the cycle after the command beat
// every slot compares against the new priority in parallel and shifts in the same edge
// reset clears the entry count and the result strobe; slot contents are left as they are
// the result receiver cannot stall, so nothing waits on the output side
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::SPQ_QUEUE_DEPTH,
    parameter int TAG_BITS    = spq_pkg::SPQ_TAG_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::spq_cmd_t cmd,
    output logic              done,
    output spq_pkg::spq_rsp_t rsp
);
    import spq_pkg::*;
    `include "sorted_priority_queue_top_assert.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    spq_rsp_t         rsp_reg, rsp_next;

    logic             accept;
    logic             is_full, is_empty;
    logic             ins_full;
    spq_ctl_t         ctl;
    logic [31:0]      tag_wide;
    logic [TAG_BITS-1:0] new_tag;
    logic [31:0]      head_tag_wide;

    logic [TAG_BITS-1:0]          cell_tag      [QUEUE_DEPTH];
    logic signed [PRIORITY_W-1:0] cell_prio     [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]          cell_tag_nx   [QUEUE_DEPTH];
    logic signed [PRIORITY_W-1:0] cell_prio_nx  [QUEUE_DEPTH];
    logic                         cell_gt       [QUEUE_DEPTH];

    // command decode
    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign ins_full = accept && (cmd.mode == MODE_INSERT) && is_full;
    assign ctl.ins  = accept && (cmd.mode == MODE_INSERT) && !is_full;
    assign ctl.pop  = accept && (cmd.mode == MODE_POP) && !is_empty;

    // tag fitted to the stored width
    assign tag_wide = {{(32 - WORD_TAG_W){1'b0}}, cmd.word_tag};
    assign new_tag  = tag_wide[TAG_BITS-1:0];

    // chain of slots
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                         lgt;
        logic [TAG_BITS-1:0]          ltag, rtag;
        logic signed [PRIORITY_W-1:0] lprio, rprio;

        if (i == 0)
        begin : g_first
            assign lgt   = 1'b0;
            assign ltag  = '0;
            assign lprio = '0;
        end
        else
        begin : g_mid
            assign lgt   = cell_gt[i-1];
            assign ltag  = cell_tag[i-1];
            assign lprio = cell_prio[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign rtag  = '0;
            assign rprio = '0;
        end
        else
        begin : g_inner
            assign rtag  = cell_tag[i+1];
            assign rprio = cell_prio[i+1];
        end

        spq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (CNT_W'(i) < count_reg),
            .new_tag    (new_tag),
            .new_prio   (cmd.priority_req),
            .left_gt    (lgt),
            .left_tag   (ltag),
            .left_prio  (lprio),
            .right_tag  (rtag),
            .right_prio (rprio),
            .gt         (cell_gt[i]),
            .tag        (cell_tag[i]),
            .prio       (cell_prio[i]),
            .tag_next   (cell_tag_nx[i]),
            .prio_next  (cell_prio_nx[i])
        );
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
            count_next = count_reg + 1'b1;
        else if (ctl.pop)
            count_next = count_reg - 1'b1;
    end

    // result beat from the head slot after this step
    assign head_tag_wide = 32'(cell_tag_nx[0]);

    always_comb
    begin
        rsp_next = '0;
        if (ins_full)
            rsp_next.status = ST_FULL;
        else if (accept && (cmd.mode == MODE_POP) && is_empty)
            rsp_next.status = ST_EMPTY;
        else
            rsp_next.status = ST_DONE;
        rsp_next.head_valid  = (count_next != '0);
        rsp_next.entry_count = ENTRY_CNT_W'(count_next);
        if (count_next != '0)
        begin
            rsp_next.head_tag      = head_tag_wide[WORD_TAG_W-1:0];
            rsp_next.head_priority = cell_prio_nx[0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks
    `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= FULL_CNT)
    `SPQ_ASSERT_NEXT(a_beat_answered, accept, done)
    `SPQ_ASSERT_NEXT(a_full_keeps_count, ins_full, count_reg == $past(count_reg))
    `SPQ_ASSERT_SAME(a_empty_head_zero, done && !rsp.head_valid, rsp.head_tag == '0 && rsp.head_priority == '0)
    `SPQ_ASSERT_SAME(a_ins_pop_excl, 1'b1, !(ctl.ins && ctl.pop))

endmodule
